### hw/rtl/pctrq_pkg.sv
package pctrq_pkg;

	// Block sizing.
	localparam int NUM_CPUS    = 8;
	localparam int QUEUE_DEPTH = 16;

	localparam int CPU_W   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOTS   = NUM_CPUS * QUEUE_DEPTH;
	localparam int SLOT_W  = $clog2(SLOTS);

	// Fixed field widths of the stream payloads.
	localparam int ACTION_W  = 2;
	localparam int CPUIDX_W  = 4;
	localparam int TASK_W    = 64;
	localparam int STATUS_W  = 3;
	localparam int COUNT_W   = 5;
	localparam int COUNT_MAX = 31;

	localparam int S_TDATA_W = 136;
	localparam int S_TUSER_W = ACTION_W;
	localparam int M_TDATA_W = 144;
	localparam int M_TUSER_W = STATUS_W + 1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ENQUEUE = 2'd0,
		ACT_DEQUEUE = 2'd1,
		ACT_QUERY   = 2'd2,
		ACT_ONLINE  = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_OFFLINE = 3'd2,
		ST_FULL    = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	// Result fields that are known at accept time; the dequeued task data
	// arrives from the slot memory's read register in the cycle after accept.
	typedef struct packed {
		status_t              status;
		logic                 task_valid;
		logic [COUNT_W-1:0]   pending_count;
		logic [COUNT_W-1:0]   online_total;
	} result_t;

endpackage

### hw/rtl/per_cpu_task_ring_queues_top.sv
// Per-processor task ring queues: one circular FIFO of QUEUE_DEPTH task
// entries (64-bit id plus 64-bit argument) for each of NUM_CPUS processors,
// with an online flag per processor and a count of online processors. Each
// input transaction carries one action (enqueue, dequeue, query fill, mark
// online) and produces exactly one result transaction, in order. The block
// takes one transaction per clock cycle when the result side keeps up; the
// result appears on the master side in the cycle after the request is
// accepted, matching the registered read port of the single synchronous
// slot memory holding all NUM_CPUS * QUEUE_DEPTH entries. Queue pointers,
// fill levels and online flags sit in flip-flops, so every request is
// resolved in the accept cycle and back-to-back requests to the same queue
// need no interlock. The slot memory needs no clearing pass after reset: a
// dequeue only ever reads an entry that an earlier enqueue wrote.
module per_cpu_task_ring_queues_top
	import pctrq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 s_tvalid,
	output logic                 s_tready,
	// Low to high: cpu_index[3:0], task_ident[67:4], task_argument[131:68], zero pad.
	input  logic [S_TDATA_W-1:0] s_tdata,
	// Low to high: action[1:0].
	input  logic [S_TUSER_W-1:0] s_tuser,

	output logic                 m_tvalid,
	input  logic                 m_tready,
	// Low to high: out_task_ident[63:0], out_task_argument[127:64],
	// pending_count[132:128], online_total[137:133], zero pad.
	output logic [M_TDATA_W-1:0] m_tdata,
	// Low to high: status[2:0], task_valid[3].
	output logic [M_TUSER_W-1:0] m_tuser
);

	// Per-processor control state.
	logic [PTR_W-1:0]    rd_ptr_q [NUM_CPUS];
	logic [PTR_W-1:0]    wr_ptr_q [NUM_CPUS];
	logic [FILL_W-1:0]   fill_q   [NUM_CPUS];
	logic [NUM_CPUS-1:0] online_q;
	logic [COUNT_W-1:0]  online_total_q;

	// Slot memory: identifier in the low half, argument in the high half.
	logic [2*TASK_W-1:0] slot_mem [SLOTS];
	logic [2*TASK_W-1:0] rd_data_q;

	// Output stage.
	logic    out_valid_s1;
	result_t res_s1;

	// Request decode.
	action_t              action;
	logic [CPUIDX_W-1:0]  cpu_index;
	logic [TASK_W-1:0]    task_ident;
	logic [TASK_W-1:0]    task_argument;
	logic [CPU_W-1:0]     cpu_sel;
	logic                 cpu_ok;
	logic                 accept;

	logic [PTR_W-1:0]     rd_ptr_cur;
	logic [PTR_W-1:0]     wr_ptr_cur;
	logic [FILL_W-1:0]    fill_cur;
	logic                 online_cur;

	logic                 do_enq;
	logic                 do_deq;
	logic                 do_online;
	logic [FILL_W-1:0]    fill_new;
	logic [COUNT_W-1:0]   total_new;
	logic [SLOT_W-1:0]    slot_base;
	logic [SLOT_W-1:0]    wr_addr;
	logic [SLOT_W-1:0]    rd_addr;
	result_t              res_d;

	assign action        = action_t'(s_tuser);
	assign cpu_index     = s_tdata[CPUIDX_W-1:0];
	assign task_ident    = s_tdata[CPUIDX_W +: TASK_W];
	assign task_argument = s_tdata[CPUIDX_W+TASK_W +: TASK_W];

	assign cpu_sel = cpu_index[CPU_W-1:0];
	assign cpu_ok  = {1'b0, cpu_index} < (CPUIDX_W+1)'(NUM_CPUS);

	// The result register is free when empty or being drained this cycle.
	assign s_tready = !out_valid_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign rd_ptr_cur = rd_ptr_q[cpu_sel];
	assign wr_ptr_cur = wr_ptr_q[cpu_sel];
	assign fill_cur   = fill_q[cpu_sel];
	assign online_cur = online_q[cpu_sel];

	assign slot_base = SLOT_W'(int'(cpu_sel) * QUEUE_DEPTH);
	assign wr_addr   = slot_base + SLOT_W'(wr_ptr_cur);
	assign rd_addr   = slot_base + SLOT_W'(rd_ptr_cur);

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + PTR_W'(1);
		end
		return n;
	endfunction

	// Resolve the request against the addressed queue's state.
	always_comb begin
		do_enq    = 1'b0;
		do_deq    = 1'b0;
		do_online = 1'b0;
		fill_new  = fill_cur;
		total_new = online_total_q;
		res_d     = '{status: ST_OK, task_valid: 1'b0, pending_count: '0,
			online_total: online_total_q};

		if (!cpu_ok) begin
			res_d.status = ST_INVALID;
		end else begin
			unique case (action)
				ACT_ENQUEUE: begin
					if (!online_cur) begin
						res_d.status = ST_OFFLINE;
					end else if (fill_cur == FILL_W'(QUEUE_DEPTH)) begin
						res_d.status = ST_FULL;
					end else begin
						do_enq   = 1'b1;
						fill_new = fill_cur + FILL_W'(1);
					end
				end
				ACT_DEQUEUE: begin
					if (fill_cur == '0) begin
						res_d.status = ST_EMPTY;
					end else begin
						do_deq           = 1'b1;
						res_d.task_valid = 1'b1;
						fill_new         = fill_cur - FILL_W'(1);
					end
				end
				ACT_QUERY: begin
				end
				ACT_ONLINE: begin
					if (!online_cur) begin
						do_online = 1'b1;
						if (online_total_q < COUNT_W'(COUNT_MAX)) begin
							total_new = online_total_q + COUNT_W'(1);
						end
					end
				end
			endcase
			res_d.pending_count = COUNT_W'(fill_new);
			res_d.online_total  = total_new;
		end
	end

	// Per-processor state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CPUS; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
				fill_q[i]   <= '0;
			end
			online_q       <= NUM_CPUS'(1);
			online_total_q <= COUNT_W'(1);
		end else if (accept) begin
			if (do_enq) begin
				wr_ptr_q[cpu_sel] <= ring_next(wr_ptr_cur);
			end
			if (do_deq) begin
				rd_ptr_q[cpu_sel] <= ring_next(rd_ptr_cur);
			end
			if (do_enq || do_deq) begin
				fill_q[cpu_sel] <= fill_new;
			end
			if (do_online) begin
				online_q[cpu_sel] <= 1'b1;
				online_total_q    <= total_new;
			end
		end
	end

	// Slot memory write port.
	always_ff @(posedge clk) begin
		if (accept && do_enq) begin
			slot_mem[wr_addr] <= {task_argument, task_ident};
		end
	end

	// Slot memory read port. The read register holds its value until the
	// next dequeue, so a stalled result keeps its task data.
	always_ff @(posedge clk) begin
		if (accept && do_deq) begin
			rd_data_q <= slot_mem[rd_addr];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			out_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
	end

	assign m_tvalid = out_valid_s1;
	assign m_tuser  = {res_s1.task_valid, res_s1.status};
	assign m_tdata  = {
		(M_TDATA_W - 2*TASK_W - 2*COUNT_W)'(0),
		res_s1.online_total,
		res_s1.pending_count,
		res_s1.task_valid ? rd_data_q : (2*TASK_W)'(0)
	};

`ifndef SYNTHESIS
	// The online count always matches the number of set online flags.
	a_online_count: assert property (@(posedge clk) disable iff (!arst_n)
		COUNT_W'($countones(online_q)) == online_total_q)
		else $error("online count differs from online flags");

	// A returned task only ever comes with an ok status.
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s1 && res_s1.task_valid |-> res_s1.status == ST_OK)
		else $error("task returned with a failing status");

	// A reported fill never exceeds the queue depth.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s1 |-> res_s1.pending_count <= COUNT_W'(QUEUE_DEPTH))
		else $error("pending count above queue depth");

	// No request is taken while a stalled result occupies the output.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s1 && !m_tready |-> !s_tready)
		else $error("request accepted over a stalled result");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import pctrq_pkg::*;

	// A run that goes quiet on both sides for longer than this limit is hung. The
	// longest quiet stretch of a healthy run is the long receiver hold below.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int TAIL_CYCLES    = 10;
	localparam int PAD_IN_W       = S_TDATA_W - CPUIDX_W - 2 * TASK_W;

	// One result transaction, field by field.
	typedef struct {
		status_t            status;
		logic               task_valid;
		logic [TASK_W-1:0]  ident;
		logic [TASK_W-1:0]  argument;
		logic [COUNT_W-1:0] pending;
		logic [COUNT_W-1:0] online;
	} task_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	// Shadow copy of the queues, online flags and online count, kept in step
	// with every request transaction the block accepts.
	logic [TASK_W-1:0] ring_ident [NUM_CPUS][QUEUE_DEPTH];
	logic [TASK_W-1:0] ring_arg   [NUM_CPUS][QUEUE_DEPTH];
	int unsigned       ring_head  [NUM_CPUS];
	int unsigned       ring_tail  [NUM_CPUS];
	int unsigned       ring_fill  [NUM_CPUS];
	bit                cpu_up     [NUM_CPUS];
	int unsigned       cpus_up;

	// Results predicted for accepted requests, oldest first.
	task_result_t predicted_results[$];

	int errors        = 0;
	int quiet_cycles  = 0;
	int hold_request  = 0;
	bit rx_bursty     = 1'b0;

	per_cpu_task_ring_queues_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The shadow state after reset: all queues empty, only processor 0 online.
	function automatic void reset_shadow();
		for (int c = 0; c < NUM_CPUS; c++) begin
			ring_head[c] = 0;
			ring_tail[c] = 0;
			ring_fill[c] = 0;
			cpu_up[c]    = (c == 0);
		end
		cpus_up = 1;
	endfunction

	// Applies one request to the shadow state and returns the result the block
	// must give for it. An out-of-range processor number touches nothing.
	function automatic task_result_t apply_request(action_t act, logic [CPUIDX_W-1:0] cpu,
			logic [TASK_W-1:0] id, logic [TASK_W-1:0] arg);
		task_result_t r;
		r.status     = ST_OK;
		r.task_valid = 1'b0;
		r.ident      = '0;
		r.argument   = '0;
		r.pending    = '0;
		if (cpu >= NUM_CPUS) begin
			r.status = ST_INVALID;
		end else begin
			case (act)
				ACT_ENQUEUE: begin
					// The online flag is checked before fullness.
					if (!cpu_up[cpu]) begin
						r.status = ST_OFFLINE;
					end else if (ring_fill[cpu] >= QUEUE_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						ring_ident[cpu][ring_tail[cpu]] = id;
						ring_arg[cpu][ring_tail[cpu]]   = arg;
						ring_tail[cpu] = (ring_tail[cpu] + 1) % QUEUE_DEPTH;
						ring_fill[cpu]++;
					end
				end
				ACT_DEQUEUE: begin
					// Dequeue ignores the online flag.
					if (ring_fill[cpu] == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.task_valid = 1'b1;
						r.ident      = ring_ident[cpu][ring_head[cpu]];
						r.argument   = ring_arg[cpu][ring_head[cpu]];
						ring_head[cpu] = (ring_head[cpu] + 1) % QUEUE_DEPTH;
						ring_fill[cpu]--;
					end
				end
				ACT_QUERY: begin
				end
				ACT_ONLINE: begin
					if (!cpu_up[cpu]) begin
						cpu_up[cpu] = 1'b1;
						if (cpus_up < COUNT_MAX)
							cpus_up++;
					end
				end
			endcase
			r.pending = COUNT_W'(ring_fill[cpu]);
		end
		r.online = COUNT_W'(cpus_up);
		return r;
	endfunction

	function automatic void check_field(string name, logic [TASK_W-1:0] want,
			logic [TASK_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	function automatic logic [TASK_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Scoreboard. Everything is sampled at the rising edge. An accepted request
	// is predicted before the result side is looked at, so that the order of
	// the two within one edge never matters.
	always @(posedge clk) begin : scoreboard
		task_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predicted_results.push_back(apply_request(action_t'(s_tuser[ACTION_W-1:0]),
					s_tdata[CPUIDX_W-1:0], s_tdata[CPUIDX_W +: TASK_W],
					s_tdata[CPUIDX_W+TASK_W +: TASK_W]));
			if (m_tvalid && m_tready) begin
				if (predicted_results.size() == 0) begin
					$error("result transaction with no request waiting for it");
					errors++;
				end else begin
					want = predicted_results.pop_front();
					check_field("status", TASK_W'(want.status),
						TASK_W'(m_tuser[STATUS_W-1:0]));
					check_field("task_valid", TASK_W'(want.task_valid),
						TASK_W'(m_tuser[STATUS_W]));
					check_field("out_task_ident", want.ident, m_tdata[TASK_W-1:0]);
					check_field("out_task_argument", want.argument, m_tdata[TASK_W +: TASK_W]);
					check_field("pending_count", TASK_W'(want.pending),
						TASK_W'(m_tdata[2*TASK_W +: COUNT_W]));
					check_field("online_total", TASK_W'(want.online),
						TASK_W'(m_tdata[2*TASK_W+COUNT_W +: COUNT_W]));
				end
			end
		end
	end

	// Watchdog: counts cycles in which no transaction happens on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	// Result-side flow control. A long hold asked for by a test is counted here;
	// otherwise, when bursty mode is on, m_tready drops for random bursts.
	// This process is the only driver of m_tready.
	initial begin : receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (rx_bursty && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offers one request transaction and returns at the edge that accepts it.
	// s_tvalid stays high afterwards, so back-to-back sends keep the stream full.
	task automatic send_item(action_t act, logic [CPUIDX_W-1:0] cpu,
			logic [TASK_W-1:0] id, logic [TASK_W-1:0] arg);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {{PAD_IN_W{1'b0}}, arg, id, cpu};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Sender gap: the request side goes quiet for a stretch set by n.
	task automatic idle_sender(int n);
		repeat (n) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
	endtask

	// Sender pause until every predicted result has been checked.
	task automatic wait_drained();
		idle_sender(1);
		while (predicted_results.size() != 0)
			@(posedge clk);
	endtask

	// Reset state, invalid processor numbers, offline and empty cases, extreme
	// task words, and a repeated mark-online.
	task automatic test_directed_cases();
		rx_bursty = 1'b0;
		send_item(ACT_QUERY, 4'd0, '0, '0);
		send_item(ACT_QUERY, 4'hF, '1, '1);
		send_item(ACT_ENQUEUE, CPUIDX_W'(NUM_CPUS), '1, '0);
		send_item(ACT_DEQUEUE, CPUIDX_W'(NUM_CPUS), '0, '1);
		send_item(ACT_ONLINE, 4'hF, '0, '0);
		send_item(ACT_ENQUEUE, 4'd1, rand_word(), rand_word());
		send_item(ACT_DEQUEUE, 4'd1, '0, '0);
		send_item(ACT_QUERY, 4'd1, '0, '0);
		send_item(ACT_DEQUEUE, 4'd0, '0, '0);
		send_item(ACT_ENQUEUE, 4'd0, '1, '1);
		send_item(ACT_ENQUEUE, 4'd0, '0, '0);
		send_item(ACT_ENQUEUE, 4'd0, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A);
		send_item(ACT_QUERY, 4'd0, '0, '0);
		send_item(ACT_ONLINE, 4'd0, '0, '0);
		send_item(ACT_ONLINE, CPUIDX_W'(NUM_CPUS - 1), '0, '0);
		send_item(ACT_ONLINE, CPUIDX_W'(NUM_CPUS - 1), '0, '0);
		send_item(ACT_ENQUEUE, CPUIDX_W'(NUM_CPUS - 1), rand_word(), rand_word());
		repeat (4)
			send_item(ACT_DEQUEUE, 4'd0, rand_word(), rand_word());
		send_item(ACT_DEQUEUE, CPUIDX_W'(NUM_CPUS - 1), '0, '0);
		wait_drained();
	endtask

	// The receiver holds off for a long stretch while one queue is filled past
	// full and then drained past empty, wrapping its pointers. The block backs
	// up and must stall the request side without losing a transaction.
	task automatic test_full_queue_under_hold();
		rx_bursty = 1'b0;
		send_item(ACT_ONLINE, 4'd3, '0, '0);
		hold_request = HOLD_CYCLES;
		repeat (QUEUE_DEPTH + 1)
			send_item(ACT_ENQUEUE, 4'd3, rand_word(), rand_word());
		repeat (QUEUE_DEPTH + 1)
			send_item(ACT_DEQUEUE, 4'd3, rand_word(), rand_word());
		wait_drained();
	endtask

	// Random traffic in segments of 32 requests. Each segment picks a focus
	// processor and leans toward filling or toward draining, so queues reach
	// both full and empty. Mark-online is rare, which keeps some processors
	// offline for a good part of the run.
	task automatic test_random_traffic(int n_items, bit with_gaps);
		int      focus;
		int      enq_weight;
		int      pick;
		int      cpu;
		action_t act;
		focus      = 0;
		enq_weight = 50;
		rx_bursty  = with_gaps;
		for (int i = 0; i < n_items; i++) begin
			if (i % 32 == 0) begin
				focus      = $urandom_range(0, NUM_CPUS - 1);
				enq_weight = ($urandom_range(0, 1) != 0) ? 70 : 25;
			end
			pick = $urandom_range(0, 99);
			if (pick < enq_weight)
				act = ACT_ENQUEUE;
			else if (pick < 90)
				act = ACT_DEQUEUE;
			else if (pick < 97)
				act = ACT_QUERY;
			else
				act = ACT_ONLINE;
			pick = $urandom_range(0, 99);
			if (pick < 60)
				cpu = focus;
			else if (pick < 90 || NUM_CPUS >= 16)
				cpu = $urandom_range(0, NUM_CPUS - 1);
			else
				cpu = $urandom_range(NUM_CPUS, 15);
			if (with_gaps && $urandom_range(0, 7) == 0)
				idle_sender($urandom_range(1, 16));
			send_item(act, CPUIDX_W'(cpu), rand_word(), rand_word());
		end
		wait_drained();
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		reset_shadow();
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_full_queue_under_hold();
		test_random_traffic(830, 1'b1);
		// The last part of the run goes at full rate on both sides.
		test_random_traffic(170, 1'b0);

		idle_sender(1);
		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
